// ===== sv/hsc_pkg.sv =====
// Shared types, constants and commutation tables for the Hall six-step commutator.
// No dependencies; every other file imports this package.
package hsc_pkg;

  localparam int unsigned PWM_STEPS   = 1024;
  localparam int unsigned COUNT_WIDTH = 16;

  localparam int unsigned HALL_W   = 3;
  localparam int unsigned DUTY_W   = 11;
  localparam int unsigned TRIG_E_W = 10;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned FREQ_W   = 20;
  localparam int unsigned CFG_W    = 20;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned DIV_CNT_W = $clog2(FREQ_W);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DUTY      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIR       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TICK_RATE = 2'd3;

  localparam logic [FREQ_W-1:0]   FREQ_MAX       = '1;
  localparam logic [FREQ_W-1:0]   TICK_RATE_RST  = FREQ_W'(50000);
  localparam logic [DUTY_W-1:0]   DUTY_MAX       = DUTY_W'(PWM_STEPS);

  // Hall codes that bound the speed measurement
  localparam logic [HALL_W-1:0] HALL_SPEED_A = 3'b001;
  localparam logic [HALL_W-1:0] HALL_SPEED_B = 3'b101;

  typedef struct packed {
    logic step;      // beat accepted: evaluate the tick
    logic div_run;   // advance the divider one bit
    logic load_out;  // capture the result beat
  } hsc_cmd_t;

  typedef struct packed {
    logic need_div;  // the accepted tick latches a nonzero period
    logic div_last;  // divider is on its final bit
  } hsc_sts_t;

  // Phase numbers: 1..3, 0 means none
  function automatic logic [1:0] low_phase(input logic dir, input logic [HALL_W-1:0] hall);
    logic [1:0] p;
    case (hall)
      3'd1:    p = dir ? 2'd2 : 2'd1;
      3'd2:    p = dir ? 2'd1 : 2'd3;
      3'd3:    p = dir ? 2'd2 : 2'd3;
      3'd4:    p = dir ? 2'd3 : 2'd2;
      3'd5:    p = dir ? 2'd3 : 2'd1;
      3'd6:    p = dir ? 2'd1 : 2'd2;
      default: p = 2'd0;
    endcase
    return p;
  endfunction

  function automatic logic [1:0] high_phase(input logic dir, input logic [HALL_W-1:0] hall);
    return low_phase(!dir, hall);
  endfunction

endpackage

// ===== sv/hsc_ctrl.sv =====
// Sequencer for the Hall six-step commutator: accept, divide, hand off result.
// Depends on hsc_pkg.
module hsc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  hsc_pkg::hsc_sts_t sts,
  output hsc_pkg::hsc_cmd_t cmd
);
  import hsc_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.step  = 1'b1;
          state_nxt = sts.need_div ? ST_DIV : ST_DONE;
        end
      end
      ST_DIV: begin
        cmd.div_run = 1'b1;
        if (sts.div_last) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== sv/hsc_datapath.sv =====
// Datapath of the Hall six-step commutator: config, gate state, idle counter,
// bit-serial frequency divider and result register. Depends on hsc_pkg.
module hsc_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [hsc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hsc_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic [hsc_pkg::HALL_W-1:0]    in_hall_bits,
  input  hsc_pkg::hsc_cmd_t             cmd,
  output hsc_pkg::hsc_sts_t             sts,
  output logic                          out_commutated,
  output logic [hsc_pkg::DUTY_W-1:0]    out_phase1_compare,
  output logic [hsc_pkg::DUTY_W-1:0]    out_phase2_compare,
  output logic [hsc_pkg::DUTY_W-1:0]    out_phase3_compare,
  output logic [hsc_pkg::HALL_W-1:0]    out_low_side_mask,
  output logic                          out_sense_enable,
  output logic [hsc_pkg::TRIG_E_W-1:0]  out_trigger_early,
  output logic [hsc_pkg::DUTY_W-1:0]    out_trigger_late,
  output logic                          out_speed_update,
  output logic [hsc_pkg::PERIOD_W-1:0]  out_period_ticks,
  output logic [hsc_pkg::FREQ_W-1:0]    out_hall_freq_hz
);
  import hsc_pkg::*;

  // Configuration
  logic [DUTY_W-1:0] duty_r;
  logic              dir_r;
  logic              enable_r;
  logic [FREQ_W-1:0] tick_rate_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_r      <= '0;
      dir_r       <= 1'b1;
      enable_r    <= 1'b0;
      tick_rate_r <= TICK_RATE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DUTY:      duty_r      <= cfg_wdata[DUTY_W-1:0];
        REG_DIR:       dir_r       <= cfg_wdata[0];
        REG_ENABLE:    enable_r    <= cfg_wdata[0];
        REG_TICK_RATE: tick_rate_r <= cfg_wdata[FREQ_W-1:0];
        default: ;
      endcase
    end
  end

  // Drive state
  logic [HALL_W-1:0]      hall_prev_r;
  logic [COUNT_WIDTH-1:0] idle_cnt_r;
  logic [DUTY_W-1:0]      cmp_r [3];
  logic [HALL_W-1:0]      low_mask_r;
  logic                   sense_r;
  logic [TRIG_E_W-1:0]    trig_early_r;
  logic [DUTY_W-1:0]      trig_late_r;
  logic [COUNT_WIDTH-1:0] period_r;
  logic [FREQ_W-1:0]      freq_r;
  logic                   commutated_r;
  logic                   speed_upd_r;

  logic              changed, latch;
  logic [DUTY_W-1:0] duty_sat;
  logic [DUTY_W:0]   late_sum;
  logic [1:0]        lo_ph, hi_ph;

  assign changed  = (hall_prev_r != in_hall_bits);
  assign latch    = ((in_hall_bits == HALL_SPEED_A) && (hall_prev_r == HALL_SPEED_B)) ||
                    ((in_hall_bits == HALL_SPEED_B) && (hall_prev_r == HALL_SPEED_A));
  assign duty_sat = (duty_r > DUTY_MAX) ? DUTY_MAX : duty_r;
  assign late_sum = {1'b0, duty_sat} + (DUTY_W+1)'(PWM_STEPS);
  assign lo_ph    = low_phase(dir_r, in_hall_bits);
  assign hi_ph    = high_phase(dir_r, in_hall_bits);

  assign sts.need_div = enable_r && latch && (idle_cnt_r != '0);

  // Restoring divider: tick_rate / period, one quotient bit a cycle
  logic [COUNT_WIDTH-1:0] div_rem_r;
  logic [COUNT_WIDTH-1:0] div_den_r;
  logic [FREQ_W-1:0]      div_q_r;
  logic [DIV_CNT_W-1:0]   div_cnt_r;
  logic [COUNT_WIDTH:0]   div_trial;
  logic                   div_ge;
  logic [COUNT_WIDTH:0]   div_diff;

  assign div_trial    = {div_rem_r, div_q_r[FREQ_W-1]};
  assign div_ge       = (div_trial >= {1'b0, div_den_r});
  assign div_diff     = div_trial - {1'b0, div_den_r};
  assign sts.div_last = (div_cnt_r == DIV_CNT_W'(FREQ_W - 1));

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      div_rem_r <= '0;
      div_den_r <= idle_cnt_r;
      div_q_r   <= tick_rate_r;
      div_cnt_r <= '0;
    end else if (cmd.div_run) begin
      div_rem_r <= div_ge ? div_diff[COUNT_WIDTH-1:0] : div_trial[COUNT_WIDTH-1:0];
      div_q_r   <= {div_q_r[FREQ_W-2:0], div_ge};
      div_cnt_r <= div_cnt_r + DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hall_prev_r  <= '0;
      idle_cnt_r   <= '0;
      cmp_r[0]     <= '0;
      cmp_r[1]     <= '0;
      cmp_r[2]     <= '0;
      low_mask_r   <= '0;
      sense_r      <= 1'b0;
      trig_early_r <= '0;
      trig_late_r  <= '0;
      period_r     <= '0;
      freq_r       <= '0;
      commutated_r <= 1'b0;
      speed_upd_r  <= 1'b0;
    end else begin
      if (cmd.step) begin
        commutated_r <= enable_r && changed;
        speed_upd_r  <= enable_r && latch;
        if (enable_r) begin
          hall_prev_r <= in_hall_bits;
          if (latch) begin
            idle_cnt_r <= '0;
            period_r   <= idle_cnt_r;
            if (idle_cnt_r == '0) freq_r <= FREQ_MAX;
          end else if (!changed && (idle_cnt_r != '1)) begin
            idle_cnt_r <= idle_cnt_r + COUNT_WIDTH'(1);
          end
          if (changed) begin
            cmp_r[0]     <= (hi_ph == 2'd1) ? duty_sat : '0;
            cmp_r[1]     <= (hi_ph == 2'd2) ? duty_sat : '0;
            cmp_r[2]     <= (hi_ph == 2'd3) ? duty_sat : '0;
            low_mask_r   <= {lo_ph == 2'd3, lo_ph == 2'd2, lo_ph == 2'd1};
            sense_r      <= (lo_ph == 2'd1);
            trig_early_r <= duty_sat[DUTY_W-1:1];
            trig_late_r  <= late_sum[DUTY_W:1];
          end
        end
      end
      if (cmd.div_run && sts.div_last) freq_r <= {div_q_r[FREQ_W-2:0], div_ge};
    end
  end

  // Result register: holds the beat while the consumer stalls
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_commutated     <= commutated_r;
      out_phase1_compare <= cmp_r[0];
      out_phase2_compare <= cmp_r[1];
      out_phase3_compare <= cmp_r[2];
      out_low_side_mask  <= low_mask_r;
      out_sense_enable   <= sense_r;
      out_trigger_early  <= trig_early_r;
      out_trigger_late   <= trig_late_r;
      out_speed_update   <= speed_upd_r;
      out_period_ticks   <= period_r[PERIOD_W-1:0];
      out_hall_freq_hz   <= freq_r;
    end
  end

endmodule

// ===== sv/hall_six_step_commutator.sv =====
// Top level of the Hall six-step commutator: sequencer plus datapath.
// Depends on hsc_pkg, hsc_ctrl and hsc_datapath.
//
//   Channel  Handshake              Payload
//   in_      in_valid / in_ready    in_hall_bits (one control tick)
//   out_     out_valid / out_ready  commutation, trigger and speed fields
//   cfg_     cfg_we (no wait)       cfg_index, cfg_wdata
//
// Flow: a tick is accepted only in idle; its result beat is loaded from the done
// state once the result register is free, after the divider state when the tick
// latches a nonzero period, since the Hall frequency comes from a restoring divider
// that produces one of its 20 quotient bits per cycle. The next tick is accepted
// from the cycle after the result is captured.
// Reset (synchronous, active low) clears the sequencer, drive state and config.
// A stalled output holds its beat in the result register; at most one finished
// beat waits there while the next tick is being worked on.
module hall_six_step_commutator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [hsc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hsc_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [hsc_pkg::HALL_W-1:0]    in_hall_bits,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_commutated,
  output logic [hsc_pkg::DUTY_W-1:0]    out_phase1_compare,
  output logic [hsc_pkg::DUTY_W-1:0]    out_phase2_compare,
  output logic [hsc_pkg::DUTY_W-1:0]    out_phase3_compare,
  output logic [hsc_pkg::HALL_W-1:0]    out_low_side_mask,
  output logic                          out_sense_enable,
  output logic [hsc_pkg::TRIG_E_W-1:0]  out_trigger_early,
  output logic [hsc_pkg::DUTY_W-1:0]    out_trigger_late,
  output logic                          out_speed_update,
  output logic [hsc_pkg::PERIOD_W-1:0]  out_period_ticks,
  output logic [hsc_pkg::FREQ_W-1:0]    out_hall_freq_hz
);
  import hsc_pkg::*;

  hsc_cmd_t cmd;
  hsc_sts_t sts;

  // Sequencer: accept a tick, run the divider when needed, hand off the beat
  hsc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: gate table lookup, idle counter, divider and result register
  hsc_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_hall_bits       (in_hall_bits),
    .cmd                (cmd),
    .sts                (sts),
    .out_commutated     (out_commutated),
    .out_phase1_compare (out_phase1_compare),
    .out_phase2_compare (out_phase2_compare),
    .out_phase3_compare (out_phase3_compare),
    .out_low_side_mask  (out_low_side_mask),
    .out_sense_enable   (out_sense_enable),
    .out_trigger_early  (out_trigger_early),
    .out_trigger_late   (out_trigger_late),
    .out_speed_update   (out_speed_update),
    .out_period_ticks   (out_period_ticks),
    .out_hall_freq_hz   (out_hall_freq_hz)
  );

endmodule
